>>> hw/rtl/hsv2rgb_pkg.sv
// hsv2rgb_pkg: constants and small helpers for the hsv to rgb pixel pipeline
// no dependencies; imported by hsv_to_rgb_pixel_unit and hsv2rgb_checker
package hsv2rgb_pkg;

    localparam int unsigned PIPE_STAGES = 6;

    // hue range is 5760 = 45 * 128, reduce by blocks of 128
    localparam int unsigned HUE_W       = 16;
    localparam int unsigned HUE_LO_W    = 7;
    localparam int unsigned HUE_HI_W    = HUE_W - HUE_LO_W;
    localparam int unsigned X_W         = 13;
    localparam int unsigned HUE_RECIP_SHIFT = 15;

    localparam logic [5:0]  HUE_BLOCKS  = 6'd45;
    localparam logic [9:0]  HUE_RECIP   = 10'd729;

    localparam int unsigned UNIT_W      = 10;
    localparam logic [UNIT_W-1:0] UNIT  = 10'd960;

    localparam logic [X_W-1:0] RED_CENTER   = 13'd2880;
    localparam logic [X_W-1:0] GREEN_CENTER = 13'd1920;
    localparam logic [X_W-1:0] BLUE_CENTER  = 13'd3840;
    localparam logic [X_W-1:0] PEAK         = 13'd1920;

    localparam int unsigned SCALE_W     = 18;
    localparam logic [SCALE_W-1:0] FULL_SCALE = 18'd244800;
    localparam logic [SCALE_W-1:0] HALF_SCALE = 18'd122400;

    localparam int unsigned NUM_W       = 26;
    localparam int unsigned RECIP_W     = 15;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP = 15'd17544;
    localparam int unsigned QUOT_W      = 9;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned CHANNELS    = 3;

    function automatic logic [X_W-1:0] abs_diff(input logic [X_W-1:0] a,
                                                 input logic [X_W-1:0] b);
        logic [X_W-1:0] d;
        begin
            if (a > b) begin
                d = a - b;
            end else begin
                d = b - a;
            end
            return d;
        end
    endfunction

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [X_W+1:0] t);
        logic [UNIT_W-1:0] c;
        begin
            if (t < 0) begin
                c = '0;
            end else if (t > $signed({5'd0, UNIT})) begin
                c = UNIT;
            end else begin
                c = t[UNIT_W-1:0];
            end
            return c;
        end
    endfunction

endpackage

>>> hw/rtl/hsv_to_rgb_pixel_unit.sv
// hsv_to_rgb_pixel_unit: six stage pipeline converting one hsv pixel to 8-bit rgb
// depends on hsv2rgb_pkg
//
// usage:
//   input channel i_valid/o_ready carries i_hue (sixteenths of a degree, any
//   16-bit value, wrapped at 360 degrees), i_saturation and i_brightness
//   (255 means full). output channel o_valid/i_ready carries o_red, o_green,
//   o_blue, one item per input item, in order.
//   throughput is one item per cycle while the receiver keeps i_ready high.
//   an accepted item reaches o_valid through six register stages, which are
//   hue wrap, channel weights, saturation product, brightness product,
//   reciprocal multiply for the divide by 244800, and the final correction.
//   each stage loads whenever it is empty or the stage after it moves, so
//   empty slots close up during a stall and o_ready only drops once all six
//   stages hold items. while i_ready is low the output item holds steady.
//   synchronous reset empties every stage; no other state is kept.
module hsv_to_rgb_pixel_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0] i_hue,
    input  logic [hsv2rgb_pkg::PIX_W-1:0] i_saturation,
    input  logic [hsv2rgb_pkg::PIX_W-1:0] i_brightness,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hsv2rgb_pkg::PIX_W-1:0] o_red,
    output logic [hsv2rgb_pkg::PIX_W-1:0] o_green,
    output logic [hsv2rgb_pkg::PIX_W-1:0] o_blue
);
    import hsv2rgb_pkg::*;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES-1:0] en;

    // stage 1: block quotient of the hue
    logic [HUE_HI_W-1:0]      r_s1_hi, n_s1_hi;
    logic [HUE_LO_W-1:0]      r_s1_lo;
    logic [3:0]               r_s1_q, n_s1_q;
    logic [PIX_W-1:0]         r_s1_sat, r_s1_bri;
    logic [HUE_HI_W+9:0]      s1_prod;

    // stage 2: channel weights
    logic [UNIT_W-1:0]        r_s2_c [CHANNELS];
    logic [UNIT_W-1:0]        n_s2_c [CHANNELS];
    logic [PIX_W-1:0]         r_s2_sat, r_s2_bri;
    logic [HUE_HI_W-1:0]      s2_qx;
    logic [HUE_HI_W-1:0]      s2_rem;
    logic [X_W-1:0]           s2_x;

    // stage 3: full scale minus saturation term
    logic [SCALE_W-1:0]       r_s3_a [CHANNELS];
    logic [SCALE_W-1:0]       n_s3_a [CHANNELS];
    logic [PIX_W-1:0]         r_s3_bri;

    // stage 4: rounded numerator
    logic [NUM_W-1:0]         r_s4_n [CHANNELS];
    logic [NUM_W-1:0]         n_s4_n [CHANNELS];

    // stage 5: quotient estimate
    logic [NUM_W-1:0]         r_s5_n [CHANNELS];
    logic [QUOT_W-1:0]        r_s5_qe [CHANNELS];
    logic [QUOT_W-1:0]        n_s5_qe [CHANNELS];

    // stage 6: corrected and clamped channel
    logic [PIX_W-1:0]         r_s6_pix [CHANNELS];
    logic [PIX_W-1:0]         n_s6_pix [CHANNELS];

    always_comb begin
        en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || i_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = i_valid;
        for (int k = 1; k < PIPE_STAGES; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[PIPE_STAGES-1];
    assign o_red   = r_s6_pix[0];
    assign o_green = r_s6_pix[1];
    assign o_blue  = r_s6_pix[2];

    always_comb begin
        n_s1_hi = i_hue[HUE_W-1:HUE_LO_W];
        s1_prod = (HUE_HI_W+10)'(n_s1_hi) * (HUE_HI_W+10)'(HUE_RECIP);
        n_s1_q  = s1_prod[HUE_HI_W+9:HUE_RECIP_SHIFT];
    end

    always_comb begin
        logic [HUE_HI_W:0] qx;
        qx     = (HUE_HI_W+1)'(r_s1_q) * (HUE_HI_W+1)'(HUE_BLOCKS);
        s2_qx  = qx[HUE_HI_W-1:0];
        s2_rem = r_s1_hi - s2_qx;
        s2_x   = {s2_rem[5:0], r_s1_lo};
        n_s2_c[0] = clamp_unit($signed({2'b00, abs_diff(s2_x, RED_CENTER)})
                               - $signed({5'd0, UNIT}));
        n_s2_c[1] = clamp_unit($signed({2'b00, PEAK})
                               - $signed({2'b00, abs_diff(s2_x, GREEN_CENTER)}));
        n_s2_c[2] = clamp_unit($signed({2'b00, PEAK})
                               - $signed({2'b00, abs_diff(s2_x, BLUE_CENTER)}));
    end

    always_comb begin
        logic [SCALE_W-1:0] t;
        logic [NUM_W-1:0]   p;
        logic [NUM_W+RECIP_W-1:0] m;
        logic [NUM_W:0]     back;
        logic [NUM_W:0]     r;
        logic [QUOT_W-1:0]  q;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            t = SCALE_W'(r_s2_sat) * SCALE_W'(UNIT - r_s2_c[ch]);
            n_s3_a[ch] = FULL_SCALE - t;

            p = NUM_W'(r_s3_bri) * NUM_W'(r_s3_a[ch]);
            n_s4_n[ch] = p + NUM_W'(HALF_SCALE);

            m = (NUM_W+RECIP_W)'(r_s4_n[ch]) * (NUM_W+RECIP_W)'(RECIP);
            n_s5_qe[ch] = m[NUM_W+RECIP_W-1:RECIP_SHIFT];

            back = (NUM_W+1)'(r_s5_qe[ch]) * (NUM_W+1)'(FULL_SCALE);
            r    = {1'b0, r_s5_n[ch]} - back;
            q    = r_s5_qe[ch] + QUOT_W'(r >= (NUM_W+1)'(FULL_SCALE));
            if (q[QUOT_W-1]) begin
                n_s6_pix[ch] = '1;
            end else begin
                n_s6_pix[ch] = q[PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < PIPE_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_hi  <= n_s1_hi;
            r_s1_lo  <= i_hue[HUE_LO_W-1:0];
            r_s1_q   <= n_s1_q;
            r_s1_sat <= i_saturation;
            r_s1_bri <= i_brightness;
        end
        if (en[1]) begin
            r_s2_c   <= n_s2_c;
            r_s2_sat <= r_s1_sat;
            r_s2_bri <= r_s1_bri;
        end
        if (en[2]) begin
            r_s3_a   <= n_s3_a;
            r_s3_bri <= r_s2_bri;
        end
        if (en[3]) begin
            r_s4_n   <= n_s4_n;
        end
        if (en[4]) begin
            r_s5_n   <= r_s4_n;
            r_s5_qe  <= n_s5_qe;
        end
        if (en[5]) begin
            r_s6_pix <= n_s6_pix;
        end
    end

endmodule

>>> hw/rtl/hsv2rgb_checker.sv
// hsv2rgb_checker: port level assertions for hsv_to_rgb_pixel_unit
// depends on hsv2rgb_pkg; bound to the top level at the end of this file
module hsv2rgb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [hsv2rgb_pkg::HUE_W-1:0] i_hue,
    input logic [hsv2rgb_pkg::PIX_W-1:0] i_saturation,
    input logic [hsv2rgb_pkg::PIX_W-1:0] i_brightness,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [hsv2rgb_pkg::PIX_W-1:0] o_red,
    input logic [hsv2rgb_pkg::PIX_W-1:0] o_green,
    input logic [hsv2rgb_pkg::PIX_W-1:0] o_blue
);
    import hsv2rgb_pkg::*;

    logic [4:0] r_rdy_hist;
    logic [5:0] r_rst_hist;
    logic       flow5;

    always_ff @(posedge i_clk) begin
        r_rdy_hist <= {r_rdy_hist[3:0], i_ready};
        r_rst_hist <= {r_rst_hist[4:0], i_rst_n};
    end

    // receiver ready and no reset over the r_rdy_hist and r_rst_hist history after an item is taken
    assign flow5 = (&r_rdy_hist) && (&r_rst_hist);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red) && $stable(o_green)
                                && $stable(o_blue))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("pipeline not empty after reset");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_valid && o_ready && i_saturation == '0, 6) && flow5
        |-> o_valid && o_red == $past(i_brightness, 6)
            && o_green == $past(i_brightness, 6) && o_blue == $past(i_brightness, 6))
        else $error("zero saturation item not gray at brightness");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_valid && o_ready && i_brightness == '0, 6) && flow5
        |-> o_valid && o_red == '0 && o_green == '0 && o_blue == '0)
        else $error("zero brightness item not black");

endmodule

bind hsv_to_rgb_pixel_unit hsv2rgb_checker u_hsv2rgb_checker (.*);
